// ----- rtl/ppas_pkg.sv -----
// Package for the polar phasor add/subtract block.
// Holds payload types, pipeline constants and the CORDIC arctangent table.
// No dependencies.
`default_nettype none
package ppas_pkg;

   localparam int unsigned CORDIC_STAGES = 16;
   localparam int unsigned GUARD         = 12;
   localparam int unsigned DW            = 36;  // rectangular datapath width
   localparam int unsigned ZW            = 34;  // angle accumulator width
   localparam logic [29:0] KINV_Q30      = 30'd652032874;
   // register stages from accept to the result strobe
   localparam int unsigned LAT           = 2 * CORDIC_STAGES + 6;
   // stages that carry the zero-vector flag
   localparam int unsigned ZLEN          = CORDIC_STAGES + 2;

   typedef struct packed {
      logic               func;
      logic        [15:0] a_amp;
      logic signed [15:0] a_phase;
      logic        [31:0] a_freq;
      logic        [15:0] b_amp;
      logic signed [15:0] b_phase;
      logic        [31:0] b_freq;
   } req_type;

   typedef struct packed {
      logic        [16:0] res_amp;
      logic signed [15:0] res_phase;
      logic        [31:0] res_freq;
      logic               freq_mismatch;
   } rsp_type;

   // arctangent of 2^-i as a 32-bit binary angle
   function automatic logic [31:0] atan_angle(input logic [4:0] i);
      logic [31:0] a;
      case (i)
         5'd0:    a = 32'd536870912;
         5'd1:    a = 32'd316933406;
         5'd2:    a = 32'd167458907;
         5'd3:    a = 32'd85004756;
         5'd4:    a = 32'd42667331;
         5'd5:    a = 32'd21354465;
         5'd6:    a = 32'd10679838;
         5'd7:    a = 32'd5340245;
         5'd8:    a = 32'd2670163;
         5'd9:    a = 32'd1335087;
         5'd10:   a = 32'd667544;
         5'd11:   a = 32'd333772;
         5'd12:   a = 32'd166886;
         5'd13:   a = 32'd83443;
         5'd14:   a = 32'd41722;
         5'd15:   a = 32'd20861;
         5'd16:   a = 32'd10430;
         5'd17:   a = 32'd5215;
         5'd18:   a = 32'd2608;
         5'd19:   a = 32'd1304;
         5'd20:   a = 32'd652;
         5'd21:   a = 32'd326;
         5'd22:   a = 32'd163;
         5'd23:   a = 32'd81;
         5'd24:   a = 32'd41;
         5'd25:   a = 32'd20;
         5'd26:   a = 32'd10;
         5'd27:   a = 32'd5;
         5'd28:   a = 32'd3;
         5'd29:   a = 32'd1;
         5'd30:   a = 32'd1;
         default: a = 32'd0;
      endcase
      return a;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/ppas_cell.sv -----
// One CORDIC micro-rotation cell, rotation or vectoring mode.
// Uses ppas_pkg for widths and the arctangent table.
`default_nettype none
module ppas_cell #(
   parameter int unsigned IDX  = 0,
   parameter bit          VECT = 1'b0
) (
   input  wire logic                           clock,
   input  wire logic signed [ppas_pkg::DW-1:0] x_d,
   input  wire logic signed [ppas_pkg::DW-1:0] y_d,
   input  wire logic signed [ppas_pkg::ZW-1:0] z_d,
   output logic signed      [ppas_pkg::DW-1:0] x_q,
   output logic signed      [ppas_pkg::DW-1:0] y_q,
   output logic signed      [ppas_pkg::ZW-1:0] z_q
);

   logic signed [ppas_pkg::DW-1:0] dx, dy;
   logic signed [ppas_pkg::ZW-1:0] at;
   logic                           up, add;
   logic signed [ppas_pkg::DW-1:0] x_in, y_in;
   logic signed [ppas_pkg::ZW-1:0] z_in;
   logic signed [ppas_pkg::DW-1:0] x_ff, y_ff;
   logic signed [ppas_pkg::ZW-1:0] z_ff;

   // pick the turn direction and step the vector
   always_comb begin
      dx  = y_d >>> IDX;
      dy  = x_d >>> IDX;
      at  = signed'({2'b00, ppas_pkg::atan_angle(5'(IDX))});
      up  = VECT ? !y_d[ppas_pkg::DW-1] : !z_d[ppas_pkg::ZW-1];
      add = (VECT == up);
      if (add) begin
         x_in = x_d + dx;
         y_in = y_d - dy;
         z_in = z_d + at;
      end else begin
         x_in = x_d - dx;
         y_in = y_d + dy;
         z_in = z_d - at;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign x_q = x_ff;
   assign y_q = y_ff;
   assign z_q = z_ff;

endmodule
`default_nettype wire

// ----- rtl/polar_phasor_add_subtract.sv -----
// Top level of the polar phasor add/subtract block.
// Uses ppas_pkg and a row of ppas_cell CORDIC cells.
//
// Usage:
//   Drive req with an item and raise start; the item is accepted at the
//   rising edge where start is high and busy is low. busy stays low, so a
//   new item may be started in every cycle.
//   Each item yields exactly one result on rsp, marked by rsp_valid for a
//   single cycle; the receiver takes it in that cycle.
// Pipeline: from accept to rsp_valid an item passes the input register,
//   prescale multiply, quadrant fold, rotation cells, sum and fold,
//   vectoring cells, gain multiply and rounding register.
// Throughput: one item per cycle; every cell and multiplier is a pipeline
//   stage that takes a new item each clock.
// Reset: synchronous, active high; clears the valid pipeline so no result
//   strobes until items arrive. Data registers are not reset.
// Stall: none; results appear in order, one cycle each.
`default_nettype none
module polar_phasor_add_subtract (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire ppas_pkg::req_type req,
   output logic                   rsp_valid,
   output ppas_pkg::rsp_type      rsp
);

   localparam int unsigned N  = ppas_pkg::CORDIC_STAGES;
   localparam int unsigned L  = ppas_pkg::LAT;
   localparam int unsigned ZL = ppas_pkg::ZLEN;
   localparam int unsigned DW = ppas_pkg::DW;
   localparam int unsigned ZW = ppas_pkg::ZW;

   // valid and sideband shift line
   logic                vld_ff [0:L-1];
   ppas_pkg::req_type   sb_ff  [0:L-2];
   logic                zr_ff  [0:ZL-1];

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < L; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= start;
         for (int i = 1; i < L; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      sb_ff[0] <= req;
      for (int i = 1; i < L - 1; i++) begin
         sb_ff[i] <= sb_ff[i-1];
      end
   end

   // prescale amplitudes by the inverse CORDIC gain
   logic [45:0] pa_prod, pb_prod;
   logic [27:0] pa_ff, pb_ff;

   assign pa_prod = 46'(sb_ff[0].a_amp) * 46'(ppas_pkg::KINV_Q30);
   assign pb_prod = 46'(sb_ff[0].b_amp) * 46'(ppas_pkg::KINV_Q30);

   always_ff @(posedge clock) begin
      pa_ff <= pa_prod[45:18];
      pb_ff <= pb_prod[45:18];
   end

   // fold phases beyond a quarter turn into the convergence range
   logic signed [DW-1:0] ax [0:N];
   logic signed [DW-1:0] ay [0:N];
   logic signed [ZW-1:0] az [0:N];
   logic signed [DW-1:0] bx [0:N];
   logic signed [DW-1:0] by [0:N];
   logic signed [ZW-1:0] bz [0:N];
   logic signed [DW-1:0] ax_in, bx_in, ax_ff, bx_ff;
   logic signed [ZW-1:0] az_in, bz_in, az_ff, bz_ff;
   logic signed [ZW-1:0] za, zb;

   localparam logic signed [ZW-1:0] QTURN = ZW'(64'sh40000000);
   localparam logic signed [ZW-1:0] HTURN = ZW'(64'sh80000000);

   always_comb begin
      za    = ZW'(signed'({sb_ff[1].a_phase, 16'h0000}));
      zb    = ZW'(signed'({sb_ff[1].b_phase, 16'h0000}));
      ax_in = DW'(signed'({1'b0, pa_ff}));
      bx_in = DW'(signed'({1'b0, pb_ff}));
      az_in = za;
      bz_in = zb;
      if (za > QTURN) begin
         ax_in = -ax_in;
         az_in = za - HTURN;
      end else if (za < -QTURN) begin
         ax_in = -ax_in;
         az_in = za + HTURN;
      end
      if (zb > QTURN) begin
         bx_in = -bx_in;
         bz_in = zb - HTURN;
      end else if (zb < -QTURN) begin
         bx_in = -bx_in;
         bz_in = zb + HTURN;
      end
   end

   always_ff @(posedge clock) begin
      ax_ff <= ax_in;
      bx_ff <= bx_in;
      az_ff <= az_in;
      bz_ff <= bz_in;
   end

   assign ax[0] = ax_ff;
   assign ay[0] = '0;
   assign az[0] = az_ff;
   assign bx[0] = bx_ff;
   assign by[0] = '0;
   assign bz[0] = bz_ff;

   // rotation cells: polar to rectangular for both operands
   for (genvar g = 0; g < N; g++) begin : g_rot
      ppas_cell #(.IDX(g), .VECT(1'b0)) u_cell_a (
         .clock(clock), .x_d(ax[g]), .y_d(ay[g]), .z_d(az[g]),
         .x_q(ax[g+1]), .y_q(ay[g+1]), .z_q(az[g+1])
      );
      ppas_cell #(.IDX(g), .VECT(1'b0)) u_cell_b (
         .clock(clock), .x_d(bx[g]), .y_d(by[g]), .z_d(bz[g]),
         .x_q(bx[g+1]), .y_q(by[g+1]), .z_q(bz[g+1])
      );
   end

   // combine the parts and fold the left half plane by a half turn
   logic signed [DW-1:0] sx, sy, vx_in, vy_in, vx_ff, vy_ff;
   logic signed [ZW-1:0] vz_in, vz_ff;
   logic                 zero_in;

   always_comb begin
      if (sb_ff[N+2].func) begin
         sx = ax[N] - bx[N];
         sy = ay[N] - by[N];
      end else begin
         sx = ax[N] + bx[N];
         sy = ay[N] + by[N];
      end
      zero_in = (sx == '0) && (sy == '0);
      vx_in   = sx;
      vy_in   = sy;
      vz_in   = '0;
      if (sx[DW-1]) begin
         vx_in = -sx;
         vy_in = -sy;
         vz_in = HTURN;
      end
   end

   always_ff @(posedge clock) begin
      vx_ff    <= vx_in;
      vy_ff    <= vy_in;
      vz_ff    <= vz_in;
      zr_ff[0] <= zero_in;
      for (int i = 1; i < ZL; i++) begin
         zr_ff[i] <= zr_ff[i-1];
      end
   end

   // vectoring cells: rectangular back to magnitude and angle
   logic signed [DW-1:0] vx [0:N];
   logic signed [DW-1:0] vy [0:N];
   logic signed [ZW-1:0] vz [0:N];

   assign vx[0] = vx_ff;
   assign vy[0] = vy_ff;
   assign vz[0] = vz_ff;

   for (genvar g = 0; g < N; g++) begin : g_vec
      ppas_cell #(.IDX(g), .VECT(1'b1)) u_cell_v (
         .clock(clock), .x_d(vx[g]), .y_d(vy[g]), .z_d(vz[g]),
         .x_q(vx[g+1]), .y_q(vy[g+1]), .z_q(vz[g+1])
      );
   end

   // remove the vectoring gain
   logic [31:0] mx;
   logic [61:0] mag_prod;
   logic [31:0] mag_ff;
   logic [31:0] ph_ff;

   assign mx       = vx[N][DW-1] ? 32'd0 : vx[N][31:0];
   assign mag_prod = 62'(mx) * 62'(ppas_pkg::KINV_Q30);

   always_ff @(posedge clock) begin
      mag_ff <= mag_prod[61:30];
      ph_ff  <= vz[N][31:0];
   end

   // round, saturate and pick the special cases
   logic [32:0]       amp_sum;
   logic [20:0]       amp_rnd;
   logic [31:0]       ph_sum;
   ppas_pkg::req_type sb_out;
   ppas_pkg::rsp_type rsp_in, rsp_ff;

   always_comb begin
      sb_out  = sb_ff[L-2];
      amp_sum = {1'b0, mag_ff} + 33'(1 << (ppas_pkg::GUARD - 1));
      amp_rnd = amp_sum[32:ppas_pkg::GUARD];
      ph_sum  = ph_ff + 32'h0000_8000;
      rsp_in.res_freq      = sb_out.a_freq;
      rsp_in.freq_mismatch = 1'b0;
      rsp_in.res_amp       = (amp_rnd > 21'h1FFFF) ? 17'h1FFFF : amp_rnd[16:0];
      rsp_in.res_phase     = signed'(ph_sum[31:16]);
      if (sb_out.a_freq != sb_out.b_freq) begin
         rsp_in.freq_mismatch = 1'b1;
         rsp_in.res_amp       = {1'b0, sb_out.a_amp};
         rsp_in.res_phase     = sb_out.a_phase;
      end else if (zr_ff[ZL-1]) begin
         rsp_in.res_amp   = '0;
         rsp_in.res_phase = '0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp       = rsp_ff;
   assign rsp_valid = vld_ff[L-1];

   // checks
   a_lat : assert property (@(posedge clock) disable iff (reset)
      start |-> ##(ppas_pkg::LAT) rsp_valid)
      else $error("accepted item produced no result");

   a_pass : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.freq_mismatch |-> rsp.res_amp[16] == 1'b0)
      else $error("mismatch pass-through amplitude out of range");

   a_freq : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp.res_freq == $past(req.a_freq, ppas_pkg::LAT))
      else $error("result frequency does not follow operand A");

   a_flag : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp.freq_mismatch ==
         ($past(req.a_freq, ppas_pkg::LAT) != $past(req.b_freq, ppas_pkg::LAT)))
      else $error("mismatch flag wrong");

endmodule
`default_nettype wire

// ----- tb/polar_phasor_add_subtract_tb.sv -----
// Testbench for polar_phasor_add_subtract: drives phasor pairs through the
// command port and checks every result against a bit-exact CORDIC predictor.
// Depends on ppas_pkg and the polar_phasor_add_subtract RTL.
`timescale 1ns / 100ps

class phasor_scoreboard;
   ppas_pkg::rsp_type pending[$];
   int errors;

   function new();
      errors = 0;
   endfunction

   // floor(m * KINV / 2^30)
   static function automatic longint unsigned gain_fix(longint unsigned m);
      longint unsigned hi, lo;
      hi = m >> 15;
      lo = m & 64'h7FFF;
      return (hi * 64'd652032874 + ((lo * 64'd652032874) >> 15)) >> 15;
   endfunction

   static function automatic longint unsigned atan_step(int i);
      longint unsigned t[16] = '{536870912, 316933406, 167458907, 85004756,
         42667331, 21354465, 10679838, 5340245, 2670163, 1335087, 667544,
         333772, 166886, 83443, 41722, 20861};
      return t[i];
   endfunction

   // rotate amplitude by phase into rectangular parts, gain removed
   static function automatic void to_rect(logic [15:0] amp, logic [15:0] ph,
                                          output longint re, output longint im);
      longint x, y, z, dx, dy;
      x = longint'(gain_fix(longint'(amp) << 12));
      y = 0;
      z = longint'(signed'(ph)) <<< 16;
      if (z > 64'sh40000000) begin
         x = -x; z -= 64'sh80000000;
      end else if (z < -64'sh40000000) begin
         x = -x; z += 64'sh80000000;
      end
      for (int i = 0; i < 16; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(atan_step(i));
         end else begin
            x += dx; y -= dy; z += longint'(atan_step(i));
         end
      end
      re = x;
      im = y;
   endfunction

   // compute expected result of one item
   static function automatic ppas_pkg::rsp_type phasor_sum(ppas_pkg::req_type r);
      ppas_pkg::rsp_type o;
      longint ra, ia, rb, ib, x, y, dx, dy;
      logic [31:0] z;
      longint unsigned mag, amp;
      o.res_freq = r.a_freq;
      o.freq_mismatch = 1'b0;
      if (r.a_freq != r.b_freq) begin
         o.res_amp = {1'b0, r.a_amp};
         o.res_phase = r.a_phase;
         o.freq_mismatch = 1'b1;
         return o;
      end
      to_rect(r.a_amp, r.a_phase, ra, ia);
      to_rect(r.b_amp, r.b_phase, rb, ib);
      x = r.func ? ra - rb : ra + rb;
      y = r.func ? ia - ib : ia + ib;
      if (x == 0 && y == 0) begin
         o.res_amp = '0;
         o.res_phase = '0;
         return o;
      end
      z = 32'h0;
      if (x < 0) begin
         x = -x; y = -y; z = 32'h80000000;
      end
      for (int i = 0; i < 16; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; z += 32'(atan_step(i));
         end else begin
            x -= dx; y += dy; z -= 32'(atan_step(i));
         end
      end
      mag = gain_fix(x < 0 ? 0 : x);
      amp = (mag + 2048) >> 12;
      if (amp > 64'h1FFFF) amp = 64'h1FFFF;
      o.res_amp = amp[16:0];
      o.res_phase = 16'((({32'h0, z}) + 64'h8000) >> 16);
      return o;
   endfunction

   function void note_item(ppas_pkg::req_type r);
      pending.push_back(phasor_sum(r));
   endfunction

   task report(string what, longint got, longint want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   task check_result(ppas_pkg::rsp_type got);
      ppas_pkg::rsp_type want;
      if (pending.size() == 0) begin
         report("unexpected result", longint'(got.res_amp), 0);
         return;
      end
      want = pending.pop_front();
      if (got.res_amp != want.res_amp) report("res_amp", got.res_amp, want.res_amp);
      if (got.res_phase != want.res_phase)
         report("res_phase", got.res_phase, want.res_phase);
      if (got.res_freq != want.res_freq) report("res_freq", got.res_freq, want.res_freq);
      if (got.freq_mismatch != want.freq_mismatch)
         report("freq_mismatch", got.freq_mismatch, want.freq_mismatch);
   endtask
endclass

module polar_phasor_add_subtract_tb;

   localparam int CYCLE_LIMIT = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic rsp_valid;
   ppas_pkg::req_type req = '0;
   ppas_pkg::rsp_type rsp;
   longint cycles = 0;
   phasor_scoreboard phasors = new();

   polar_phasor_add_subtract dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req(req), .rsp_valid(rsp_valid), .rsp(rsp)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // count cycles, give up at the limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // check each strobed result
   always @(posedge clock) begin
      if (!reset && rsp_valid) phasors.check_result(rsp);
   end

   // drive one item, wait for accept, then idle for the given gap
   task automatic send_item(ppas_pkg::req_type r, int gap);
      req <= r;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      phasors.note_item(r);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic ppas_pkg::req_type rand_item(bit same_freq);
      ppas_pkg::req_type r;
      r.func = 1'($urandom_range(0, 1));
      r.a_amp = 16'($urandom);
      r.a_phase = 16'($urandom);
      r.a_freq = $urandom;
      r.b_amp = 16'($urandom);
      r.b_phase = 16'($urandom);
      r.b_freq = same_freq ? r.a_freq : $urandom;
      case ($urandom_range(0, 3))
         0: r.a_amp = 16'($urandom_range(0, 255));
         1: r.b_amp = r.a_amp;
         default: ;
      endcase
      return r;
   endfunction

   function automatic ppas_pkg::req_type item(bit f, logic [15:0] aa, logic [15:0] ap,
                                              logic [15:0] ba, logic [15:0] bp,
                                              bit match);
      ppas_pkg::req_type r;
      r.func = f; r.a_amp = aa; r.a_phase = ap; r.a_freq = 32'hFFFF_FFFF;
      r.b_amp = ba; r.b_phase = bp; r.b_freq = match ? 32'hFFFF_FFFF : 32'h0;
      return r;
   endfunction

   initial begin
      int gap;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: extremes, both operations, special cases
      send_item(item(1'b0, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 1'b1), 0);
      send_item(item(1'b1, 16'hFFFF, 16'h8000, 16'h0000, 16'h7FFF, 1'b1), 0);
      send_item(item(1'b1, 16'h1234, 16'h2000, 16'h1234, 16'h2000, 1'b1), 0);
      send_item(item(1'b0, 16'h1234, 16'h0000, 16'h1234, 16'h8000, 1'b1), 0);
      send_item(item(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1), 0);
      send_item(item(1'b0, 16'h0100, 16'h6000, 16'h0100, 16'h7000, 1'b1), 0);
      send_item(item(1'b0, 16'h0100, 16'hA000, 16'h0080, 16'h9000, 1'b1), 0);
      send_item(item(1'b1, 16'h0100, 16'h0000, 16'h0200, 16'h0000, 1'b1), 0);
      send_item(item(1'b0, 16'h0100, 16'h7FFF, 16'h0100, 16'h8001, 1'b1), 0);
      send_item(item(1'b0, 16'h0100, 16'h4000, 16'h0100, 16'hC000, 1'b1), 0);
      send_item(item(1'b1, 16'hFFFF, 16'h4000, 16'hFFFF, 16'hC000, 1'b1), 0);
      send_item(item(1'b0, 16'hABCD, 16'h5555, 16'h1111, 16'h2222, 1'b0), 0);
      send_item(item(1'b1, 16'h0001, 16'h8000, 16'h0001, 16'h0000, 1'b1), 3);
      // random: mostly matching frequencies, with idle gaps and back-to-back stretches
      for (int n = 0; n < 1150; n++) begin
         if (n % 200 < 40) gap = 0;
         else gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : 0;
         send_item(rand_item($urandom_range(0, 9) != 0), gap);
      end
      start <= 1'b0;
      while (phasors.pending.size() != 0) @(posedge clock);
      repeat (ppas_pkg::LAT + 4) @(posedge clock);
      if (phasors.errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end
endmodule

// ----- filelist.f -----
rtl/ppas_pkg.sv
rtl/ppas_cell.sv
rtl/polar_phasor_add_subtract.sv
tb/polar_phasor_add_subtract_tb.sv
